// ===== sv/vtpd_pkg.sv =====
// Shared constants and types for the vertex transform with perspective divide.
// No dependencies; every other file in sv/ imports this package.
package vtpd_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  // Operation carried by each input beat
  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_XFORM = 1'b1
  } op_e;

  // Number of divider register stages, from its input register to its saturated result register
  function automatic int div_latency(int dw);
    return dw + 2;
  endfunction

endpackage

// ===== sv/vtpd_divider.sv =====
// Pipelined signed divider with saturation, one quotient bit per stage.
// Depends on vtpd_pkg; instantiated three times by vertex_transform_perspective_divide.
module vtpd_divider
  import vtpd_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  localparam int PW = 2 * DATA_WIDTH,
  localparam int SW = PW + 2,
  localparam int AW = SW - FRAC_BITS,
  localparam int NW = SW
) (
  input  logic                         clk_i,
  input  logic                         en_i,
  input  logic signed [NW-1:0]         num_i,
  input  logic signed [AW-1:0]         den_i,
  output logic signed [DATA_WIDTH-1:0] quo_o,
  output logic                         ovf_o
);

  localparam int DW = DATA_WIDTH;
  localparam int HW = NW - DW;
  localparam int RW = (AW > HW) ? AW : HW;

  logic [NW-1:0] nm;
  logic [AW-1:0] dm;
  logic          pre_ovf;

  logic [RW-1:0] rem_q [DW+1];
  logic [DW-1:0] low_q [DW+1];
  logic [DW-1:0] quo_q [DW+1];
  logic [AW-1:0] dm_q  [DW+1];
  logic          neg_q [DW+1];
  logic          ovf_q [DW+1];

  // Take magnitudes and flag quotients that cannot fit DW magnitude bits
  always_comb begin
    nm = num_i[NW-1] ? (~NW'(num_i) + NW'(1)) : NW'(num_i);
    dm = den_i[AW-1] ? (~AW'(den_i) + AW'(1)) : AW'(den_i);
    pre_ovf = (RW'(nm[NW-1:DW]) >= RW'(dm));
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= RW'(nm[NW-1:DW]);
      low_q[0] <= nm[DW-1:0];
      quo_q[0] <= '0;
      dm_q[0]  <= dm;
      neg_q[0] <= num_i[NW-1] ^ den_i[AW-1];
      ovf_q[0] <= pre_ovf;
    end
  end

  // Restoring steps: shift in one numerator bit, subtract when it fits
  for (genvar k = 1; k <= DW; k++) begin : g_step
    logic [RW:0] trial;
    logic        fits;

    always_comb begin
      trial = {rem_q[k-1], low_q[k-1][DW-1]};
      fits  = (trial >= (RW+1)'(dm_q[k-1]));
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= fits ? RW'(trial - (RW+1)'(dm_q[k-1])) : trial[RW-1:0];
        low_q[k] <= low_q[k-1] << 1;
        quo_q[k] <= {quo_q[k-1][DW-2:0], fits};
        dm_q[k]  <= dm_q[k-1];
        neg_q[k] <= neg_q[k-1];
        ovf_q[k] <= ovf_q[k-1];
      end
    end
  end

  // Apply sign and saturate to DW signed bits
  localparam logic [DW-1:0] SMIN = {1'b1, {(DW-1){1'b0}}};
  localparam logic [DW-1:0] SMAX = {1'b0, {(DW-1){1'b1}}};

  logic [DW-1:0] mag;
  logic [DW-1:0] res_d;
  logic          sat_d;

  always_comb begin
    mag = quo_q[DW];
    if (ovf_q[DW]) begin
      res_d = neg_q[DW] ? SMIN : SMAX;
      sat_d = 1'b1;
    end else if (!neg_q[DW]) begin
      res_d = mag[DW-1] ? SMAX : mag;
      sat_d = mag[DW-1];
    end else if (mag > SMIN) begin
      res_d = SMIN;
      sat_d = 1'b1;
    end else begin
      res_d = ~mag + DW'(1);
      sat_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      quo_o <= res_d;
      ovf_o <= sat_d;
    end
  end

endmodule

// ===== sv/vertex_transform_perspective_divide.sv =====
// Top level: 4x4 matrix store, point transform pipeline, three dividers, output skid.
// Depends on vtpd_pkg and vtpd_divider.
//
//   channel | signals                                   | role
//   in      | in_valid_i / in_ready_o, opcode_i ...     | load element or transform point
//   out     | out_valid_o / out_ready_i, out_x_o ...    | one beat per transform beat
//
// One beat enters per cycle while the skid register is empty. A transform beat passes
// through the input register, multiply, sum, divider setup, then the divider pipeline
// of one quotient bit per stage plus setup and saturation stages.
// Reset clears the matrix to zero and all valid bits. A stalled output fills a
// one-beat skid register, after which the whole pipeline holds in place.
module vertex_transform_perspective_divide
  import vtpd_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         opcode_i,
  input  logic [3:0]                   element_index_i,
  input  logic signed [DATA_WIDTH-1:0] element_value_i,
  input  logic signed [DATA_WIDTH-1:0] point_x_i,
  input  logic signed [DATA_WIDTH-1:0] point_y_i,
  input  logic signed [DATA_WIDTH-1:0] point_z_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [DATA_WIDTH-1:0] out_x_o,
  output logic signed [DATA_WIDTH-1:0] out_y_o,
  output logic signed [DATA_WIDTH-1:0] out_z_o,
  output logic                         w_zero_o,
  output logic                         overflow_o
);

  localparam int DW  = DATA_WIDTH;
  localparam int PW  = 2 * DW;
  localparam int SW  = PW + 2;
  localparam int AW  = SW - FRAC_BITS;
  localparam int NW  = SW;
  localparam int LAT = div_latency(DW);

  logic en;
  logic skid_v_q;

  assign en         = !skid_v_q;
  assign in_ready_o = en;

  // Stage A: register the input beat
  logic          a_v_q;
  op_e           a_op_q;
  logic [3:0]    a_idx_q;
  logic [DW-1:0] a_val_q;
  logic signed [DW-1:0] a_pt_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
    end else if (en) begin
      a_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_op_q    <= op_e'(opcode_i);
      a_idx_q   <= element_index_i;
      a_val_q   <= element_value_i;
      a_pt_q[0] <= point_x_i;
      a_pt_q[1] <= point_y_i;
      a_pt_q[2] <= point_z_i;
    end
  end

  // Matrix store: load beats write here when they leave stage A
  logic signed [DW-1:0] mat_q [16];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 16; i++) mat_q[i] <= '0;
    end else if (en && a_v_q && (a_op_q == OP_LOAD)) begin
      mat_q[a_idx_q] <= a_val_q;
    end
  end

  // Stage B: twelve products plus the translation row; drop load beats
  logic                 b_v_q;
  logic signed [PW-1:0] prod_q [3][4];
  logic signed [DW-1:0] tr_q   [4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_v_q <= 1'b0;
    end else if (en) begin
      b_v_q <= a_v_q && (a_op_q == OP_XFORM);
    end
  end

  for (genvar c = 0; c < 4; c++) begin : g_col
    for (genvar r = 0; r < 3; r++) begin : g_row
      always_ff @(posedge clk_i) begin
        if (en) prod_q[r][c] <= a_pt_q[r] * mat_q[r*4 + c];
      end
    end
    always_ff @(posedge clk_i) begin
      if (en) tr_q[c] <= mat_q[12 + c];
    end
  end

  // Stage C: full-precision sums shifted down to the accumulator format
  logic                 c_v_q;
  logic signed [AW-1:0] acc_q [4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_v_q <= 1'b0;
    end else if (en) begin
      c_v_q <= b_v_q;
    end
  end

  for (genvar c = 0; c < 4; c++) begin : g_sum
    logic signed [SW-1:0] sum;
    always_comb begin
      sum = SW'(prod_q[0][c]) + SW'(prod_q[1][c]) + SW'(prod_q[2][c])
          + (SW'(tr_q[c]) <<< FRAC_BITS);
    end
    always_ff @(posedge clk_i) begin
      if (en) acc_q[c] <= AW'(sum >>> FRAC_BITS);
    end
  end

  // Stage D: pick divider operands; a zero w divides the raw value by one
  logic                 d_v_q;
  logic                 d_wz_q;
  logic signed [NW-1:0] num_q [3];
  logic signed [AW-1:0] den_q;
  logic                 wz;

  assign wz = (acc_q[3] == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_v_q <= 1'b0;
    end else if (en) begin
      d_v_q <= c_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d_wz_q <= wz;
      den_q  <= wz ? AW'(1) : acc_q[3];
      for (int i = 0; i < 3; i++) begin
        num_q[i] <= wz ? NW'(acc_q[i]) : (NW'(acc_q[i]) <<< FRAC_BITS);
      end
    end
  end

  // Divider lanes
  logic signed [DW-1:0] quo [3];
  logic                 sat [3];

  for (genvar i = 0; i < 3; i++) begin : g_div
    vtpd_divider #(
      .DATA_WIDTH(DATA_WIDTH),
      .FRAC_BITS (FRAC_BITS)
    ) u_div (
      .clk_i(clk_i),
      .en_i (en),
      .num_i(num_q[i]),
      .den_i(den_q),
      .quo_o(quo[i]),
      .ovf_o(sat[i])
    );
  end

  // Valid and zero-w flag travel alongside the divider stages
  logic lv_q  [LAT];
  logic lwz_q [LAT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LAT; i++) lv_q[i] <= 1'b0;
    end else if (en) begin
      lv_q[0] <= d_v_q;
      for (int i = 1; i < LAT; i++) lv_q[i] <= lv_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      lwz_q[0] <= d_wz_q;
      for (int i = 1; i < LAT; i++) lwz_q[i] <= lwz_q[i-1];
    end
  end

  // Output skid: catch the last stage when the consumer stalls
  logic                 last_v;
  logic                 last_ov;
  logic signed [DW-1:0] skid_x_q, skid_y_q, skid_z_q;
  logic                 skid_wz_q, skid_ov_q;

  assign last_v  = lv_q[LAT-1];
  assign last_ov = sat[0] | sat[1] | sat[2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_v_q <= 1'b0;
    end else if (en && last_v && !out_ready_i) begin
      skid_v_q <= 1'b1;
    end else if (skid_v_q && out_ready_i) begin
      skid_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      skid_x_q  <= quo[0];
      skid_y_q  <= quo[1];
      skid_z_q  <= quo[2];
      skid_wz_q <= lwz_q[LAT-1];
      skid_ov_q <= last_ov;
    end
  end

  assign out_valid_o = skid_v_q | last_v;
  assign out_x_o     = skid_v_q ? skid_x_q  : quo[0];
  assign out_y_o     = skid_v_q ? skid_y_q  : quo[1];
  assign out_z_o     = skid_v_q ? skid_z_q  : quo[2];
  assign w_zero_o    = skid_v_q ? skid_wz_q : lwz_q[LAT-1];
  assign overflow_o  = skid_v_q ? skid_ov_q : last_ov;

  // Checks
  a_skid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q && !out_ready_i |=> skid_v_q)
    else $error("skid beat dropped while stalled");

  a_load_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && a_v_q && (a_op_q == OP_LOAD) |=> !b_v_q)
    else $error("load beat entered the transform pipeline");

  a_load_written: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && a_v_q && (a_op_q == OP_LOAD) |=> mat_q[$past(a_idx_q)] == $past(a_val_q))
    else $error("matrix element not written");

  a_stall_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |=> $stable(lv_q[LAT-1]) || !$past(skid_v_q))
    else $error("pipeline moved while skid full");

endmodule
